// File: hw/rtl/ddh_pkg.sv
// Shared types, constants and the arctangent table of the heading PD core.
// No dependencies; used by every module in hw/rtl.
package ddh_pkg;

  localparam int CordicSteps = 16;
  localparam int CordicW     = 28;
  localparam int CfgIdxW     = 4;
  localparam int CfgDataW    = 18;

  // atan(2^-i), 2^32 = full turn
  localparam logic [31:0] AtanTable [0:23] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  typedef enum logic [CfgIdxW-1:0] {
    CfgPropGain  = 4'd0,
    CfgDerivGain = 4'd1,
    CfgBaseSpeed = 4'd2,
    CfgRevThresh = 4'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [17:0] prop_gain;
    logic [17:0] deriv_gain;
    logic [6:0]  base_speed;
    logic [14:0] rev_thresh;
  } cfg_t;

  typedef struct packed {
    logic signed [15:0] robot_x;
    logic signed [15:0] robot_y;
    logic signed [15:0] heading;
    logic signed [15:0] target_x;
    logic signed [15:0] target_y;
    logic [1:0]         id;
  } item_t;

  typedef struct packed {
    logic signed [CordicW-1:0] x;
    logic signed [CordicW-1:0] y;
    logic [31:0]               z;
    logic                      zero;
    logic signed [15:0]        heading;
    logic [1:0]                id;
  } cor_t;

endpackage

// File: hw/rtl/diff_drive_heading_pd_core.sv
// Top level of the differential-drive heading PD core: input register,
// configuration registers, CORDIC pipeline and PD section. Depends on ddh_pkg.
//
// One word is accepted per cycle and one result word leaves per cycle while
// out_stall_i is low. A word passes the input register, CordicSteps + 1 CORDIC
// stages and three PD stages before out_valid_o rises for it. Results leave in
// order, and the shared last-error register is updated in that order. Stalls on
// the output fill the pipeline before in_stall_o rises. Configuration writes are
// always taken and must happen while the pipeline is empty.
module diff_drive_heading_pd_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [ddh_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [ddh_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [15:0]           robot_x_i,
  input  logic signed [15:0]           robot_y_i,
  input  logic signed [15:0]           robot_heading_i,
  input  logic signed [15:0]           target_x_i,
  input  logic signed [15:0]           target_y_i,
  input  logic [1:0]                   bot_id_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [1:0]                   out_bot_id_o,
  output logic signed [16:0]           left_speed_o,
  output logic signed [16:0]           right_speed_o,
  output logic                         drove_reversed_o
);
  import ddh_pkg::*;

  cfg_t  cfg_q;
  item_t in_q;
  logic  in_vld_q, in_rdy;
  logic  cor_in_rdy;
  logic  cor_vld, pd_rdy;
  cor_t  cor;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.prop_gain  <= 18'd32170;
      cfg_q.deriv_gain <= 18'd4021;
      cfg_q.base_speed <= 7'd30;
      cfg_q.rev_thresh <= 15'd18022;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CfgPropGain:  cfg_q.prop_gain  <= cfg_data_i;
        CfgDerivGain: cfg_q.deriv_gain <= cfg_data_i;
        CfgBaseSpeed: cfg_q.base_speed <= cfg_data_i[6:0];
        CfgRevThresh: cfg_q.rev_thresh <= cfg_data_i[14:0];
        default: ;
      endcase
    end
  end

  assign in_rdy     = !in_vld_q || cor_in_rdy;
  assign in_stall_o = !in_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_rdy) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_rdy && in_valid_i) begin
      in_q.robot_x  <= robot_x_i;
      in_q.robot_y  <= robot_y_i;
      in_q.heading  <= robot_heading_i;
      in_q.target_x <= target_x_i;
      in_q.target_y <= target_y_i;
      in_q.id       <= bot_id_i;
    end
  end

  ddh_cordic u_cordic (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_vld_q),
    .in_ready_o  (cor_in_rdy),
    .in_item_i   (in_q),
    .out_valid_o (cor_vld),
    .out_ready_i (pd_rdy),
    .out_cor_o   (cor)
  );

  ddh_pd u_pd (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg_q),
    .in_valid_i       (cor_vld),
    .in_ready_o       (pd_rdy),
    .in_cor_i         (cor),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_bot_id_o     (out_bot_id_o),
    .left_speed_o     (left_speed_o),
    .right_speed_o    (right_speed_o),
    .drove_reversed_o (drove_reversed_o)
  );

endmodule

// File: hw/rtl/ddh_cordic.sv
// Pipelined CORDIC vectoring unit: pre-rotation stage, then one iteration per stage.
// Depends on ddh_pkg.
module ddh_cordic (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  ddh_pkg::item_t in_item_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output ddh_pkg::cor_t  out_cor_o
);
  import ddh_pkg::*;

  localparam int NStg = CordicSteps + 1;

  cor_t            stg_q  [NStg];
  cor_t            stg_d  [NStg];
  logic [NStg-1:0] vld_q;
  logic [NStg-1:0] up_vld;
  logic [NStg-1:0] rdy;
  logic [NStg-1:0] dn_rdy;

  logic signed [16:0]        dx, dy;
  logic signed [CordicW-1:0] x0, y0;

  // pre-rotation into the right half plane
  always_comb begin
    dx = {in_item_i.target_x[15], in_item_i.target_x}
       - {in_item_i.robot_x[15], in_item_i.robot_x};
    dy = {in_item_i.target_y[15], in_item_i.target_y}
       - {in_item_i.robot_y[15], in_item_i.robot_y};
    x0 = {{(CordicW-25){dx[16]}}, dx, 8'd0};
    y0 = {{(CordicW-25){dy[16]}}, dy, 8'd0};
    stg_d[0].heading = in_item_i.heading;
    stg_d[0].id      = in_item_i.id;
    stg_d[0].zero    = (dx == 17'sd0) && (dy == 17'sd0);
    if (dx[16]) begin
      stg_d[0].x = -x0;
      stg_d[0].y = -y0;
      stg_d[0].z = 32'h8000_0000;
    end else begin
      stg_d[0].x = x0;
      stg_d[0].y = y0;
      stg_d[0].z = 32'd0;
    end
  end

  assign up_vld[0] = in_valid_i;

  for (genvar k = 1; k < NStg; k++) begin : g_iter
    localparam int I = k - 1;
    logic signed [CordicW-1:0] xp, yp, xs, ys;
    logic                      ypos;
    assign xp   = stg_q[k-1].x;
    assign yp   = stg_q[k-1].y;
    assign xs   = xp >>> I;
    assign ys   = yp >>> I;
    assign ypos = !yp[CordicW-1] && (yp != '0);
    always_comb begin
      stg_d[k] = stg_q[k-1];
      if (ypos) begin
        stg_d[k].x = xp + ys;
        stg_d[k].y = yp - xs;
        stg_d[k].z = stg_q[k-1].z + AtanTable[I];
      end else begin
        stg_d[k].x = xp - ys;
        stg_d[k].y = yp + xs;
        stg_d[k].z = stg_q[k-1].z - AtanTable[I];
      end
    end
    assign up_vld[k] = vld_q[k-1];
  end

  for (genvar k = 0; k < NStg; k++) begin : g_stg
    if (k == NStg - 1) begin : g_last
      assign dn_rdy[k] = out_ready_i;
    end else begin : g_mid
      assign dn_rdy[k] = rdy[k+1];
    end
    assign rdy[k] = !vld_q[k] || dn_rdy[k];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (rdy[k]) begin
        vld_q[k] <= up_vld[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[k] && up_vld[k]) begin
        stg_q[k] <= stg_d[k];
      end
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = vld_q[NStg-1];
  assign out_cor_o   = stg_q[NStg-1];

endmodule

// File: hw/rtl/ddh_pd.sv
// Heading error, reverse decision, PD term and wheel mixing; three stages.
// Depends on ddh_pkg; holds the shared last-error register.
module ddh_pd (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ddh_pkg::cfg_t      cfg_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  ddh_pkg::cor_t      in_cor_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         out_bot_id_o,
  output logic signed [16:0] left_speed_o,
  output logic signed [16:0] right_speed_o,
  output logic               drove_reversed_o
);
  import ddh_pkg::*;

  // error stage
  logic [31:0]        z_rnd;
  logic [15:0]        bearing;
  logic [15:0]        e0;
  logic [16:0]        mag;
  logic               rev_d;
  logic [15:0]        e_d;
  logic               e_vld_q, e_rdy, e_load;
  logic signed [15:0] e_q;
  logic               e_rev_q;
  logic [1:0]         e_id_q;

  assign z_rnd   = in_cor_i.z + 32'h0000_8000;
  assign bearing = in_cor_i.zero ? 16'd0 : z_rnd[31:16];
  assign e0      = in_cor_i.heading - bearing;
  assign mag     = e0[15] ? (17'd0 - {e0[15], e0}) : {1'b0, e0};
  assign rev_d   = mag > {2'b00, cfg_i.rev_thresh};
  assign e_d     = rev_d ? {~e0[15], e0[14:0]} : e0;

  // multiply stage
  logic signed [16:0] diff;
  logic signed [34:0] pp_d;
  logic signed [35:0] pd_d;
  logic               m_vld_q, m_rdy, m_load;
  logic signed [34:0] pp_q;
  logic signed [35:0] pd_q;
  logic               m_rev_q;
  logic [1:0]         m_id_q;
  logic signed [15:0] prev_err_q;

  assign diff = {e_q[15], e_q} - {prev_err_q[15], prev_err_q};
  assign pp_d = $signed({1'b0, cfg_i.prop_gain}) * e_q;
  assign pd_d = $signed({1'b0, cfg_i.deriv_gain}) * diff;

  // output stage
  logic signed [36:0] s_sum;
  logic signed [36:0] s_rnd;
  logic signed [20:0] motor_raw;
  logic signed [20:0] base_w;
  logic signed [16:0] base17;
  logic signed [16:0] motor;
  logic signed [16:0] left_d, right_d;
  logic               o_rdy, o_load;

  assign s_sum     = {{2{pp_q[34]}}, pp_q} + {pd_q[35], pd_q};
  assign s_rnd     = s_sum + 37'sd32768;
  assign motor_raw = s_rnd[36:16];
  assign base_w    = {6'd0, cfg_i.base_speed, 8'd0};
  assign base17    = {2'b00, cfg_i.base_speed, 8'd0};

  always_comb begin
    priority if (motor_raw > base_w) begin
      motor = base17;
    end else if (motor_raw < -base_w) begin
      motor = -base17;
    end else begin
      motor = motor_raw[16:0];
    end
  end

  always_comb begin
    unique case ({m_rev_q, motor > 17'sd0})
      2'b01: begin
        left_d  = base17;
        right_d = base17 - motor;
      end
      2'b00: begin
        left_d  = base17 + motor;
        right_d = base17;
      end
      2'b11: begin
        left_d  = motor - base17;
        right_d = -base17;
      end
      default: begin
        left_d  = -base17;
        right_d = -base17 - motor;
      end
    endcase
  end

  // handshake chain
  assign o_rdy      = !out_valid_o || !out_stall_i;
  assign m_rdy      = !m_vld_q || o_rdy;
  assign e_rdy      = !e_vld_q || m_rdy;
  assign in_ready_o = e_rdy;
  assign e_load     = in_valid_i && e_rdy;
  assign m_load     = e_vld_q && m_rdy;
  assign o_load     = m_vld_q && o_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_vld_q     <= 1'b0;
      m_vld_q     <= 1'b0;
      out_valid_o <= 1'b0;
      prev_err_q  <= '0;
    end else begin
      if (e_rdy) begin
        e_vld_q <= in_valid_i;
      end
      if (m_rdy) begin
        m_vld_q <= e_vld_q;
      end
      if (o_rdy) begin
        out_valid_o <= m_vld_q;
      end
      if (m_load) begin
        prev_err_q <= e_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (e_load) begin
      e_q     <= e_d;
      e_rev_q <= rev_d;
      e_id_q  <= in_cor_i.id;
    end
    if (m_load) begin
      pp_q    <= pp_d;
      pd_q    <= pd_d;
      m_rev_q <= e_rev_q;
      m_id_q  <= e_id_q;
    end
    if (o_load) begin
      left_speed_o     <= left_d;
      right_speed_o    <= right_d;
      drove_reversed_o <= m_rev_q;
      out_bot_id_o     <= m_id_q;
    end
  end

  a_fwd_nonneg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !drove_reversed_o |-> !left_speed_o[16] && !right_speed_o[16])
    else $error("forward word with negative wheel speed");

  a_rev_nonpos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && drove_reversed_o |->
      (left_speed_o[16] || left_speed_o == 17'sd0) &&
      (right_speed_o[16] || right_speed_o == 17'sd0))
    else $error("reversed word with positive wheel speed");

  a_one_wheel_base: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !drove_reversed_o |-> left_speed_o == base17 || right_speed_o == base17)
    else $error("forward word with neither wheel at base speed");

  a_prev_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_load |=> prev_err_q == $past(e_q))
    else $error("last-error register not updated");

endmodule
